FILE: rtl/lrdf_pkg.sv
// ----------------------------------------------------------------------------
// lrdf_pkg: shared types, constants and tables for the line ring direction finder
// Widths of the fixed fields, the ring cosine table, the CORDIC arctangent table
// and the records that pass between the front part, the queue and the back part.
// ----------------------------------------------------------------------------
package lrdf_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int INDEX_W         = 4;
  localparam int ANGLE_W         = 9;
  localparam int COUNT_W         = 5;
  localparam int WEIGHT_W        = SAMPLE_W + 1;

  localparam int NUM_SENSORS_DEF = 16;
  localparam int COEF_FRAC_DEF   = 14;
  localparam int QUEUE_DEPTH     = 2;

  localparam int WEIGHT_TOP      = 1023;
  localparam int HELD_VALUE      = 10;
  localparam int SIDE_RESET      = 500;
  localparam int COUNT_MAX       = (1 << COUNT_W) - 1;

  localparam int TABLE_FRAC      = 18;
  localparam int RING_POS        = 1 << INDEX_W;
  localparam int SIN_OFFSET      = 12;

  localparam int CORDIC_STEPS    = 16;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);
  localparam int PRESCALE        = 8;
  localparam int DEG_SHIFT       = 16;
  localparam int DEG_ONE         = 1 << DEG_SHIFT;
  localparam int FULL_TURN       = 360;
  localparam int QUARTER_Q16     = 90 * DEG_ONE;
  localparam int Z_W             = 26;

  // cos(k * 22.5 deg) in Q1.18
  localparam int COS_Q18 [RING_POS] = '{
    262144, 242189, 185364, 100318, 0, -100318, -185364, -242189,
    -262144, -242189, -185364, -100318, 0, 100318, 185364, 242189
  };

  // atan(2^-i) in degrees, Q16
  localparam int ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               right_line;
    logic               left_line;
    logic               back_line;
  } frame_info_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Ring coefficient rounded from Q1.18 down to Q1.frac, magnitude rounded half up
  function automatic int coef_of(logic [INDEX_W-1:0] k, int frac);
    int v;
    int mag;
    int s;
    bit neg;
    v   = COS_Q18[k];
    neg = (v < 0);
    mag = neg ? -v : v;
    s   = TABLE_FRAC - frac;
    if (s > 0) begin
      mag = (mag + (1 << (s - 1))) >>> s;
    end
    return neg ? -mag : mag;
  endfunction

endpackage

FILE: rtl/lrdf_ifs.sv
// ----------------------------------------------------------------------------
// lrdf_ifs: sample and result channels
// Valid/ready channels; a word moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
interface lrdf_sample_if;
  import lrdf_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sensor_sample;
  logic [INDEX_W-1:0]  sensor_index;
  logic [SAMPLE_W-1:0] judge_level;
  logic [SAMPLE_W-1:0] right_sample;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] back_sample;

  modport source (
    output valid, sensor_sample, sensor_index, judge_level,
    output right_sample, left_sample, back_sample,
    input  ready
  );

  modport sink (
    input  valid, sensor_sample, sensor_index, judge_level,
    input  right_sample, left_sample, back_sample,
    output ready
  );
endinterface

interface lrdf_result_if;
  import lrdf_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] line_angle;
  logic               line_seen;
  logic [COUNT_W-1:0] active_count;
  logic               right_line;
  logic               left_line;
  logic               back_line;

  modport source (
    output valid, line_angle, line_seen, active_count,
    output right_line, left_line, back_line,
    input  ready
  );

  modport sink (
    input  valid, line_angle, line_seen, active_count,
    input  right_line, left_line, back_line,
    output ready
  );
endinterface

FILE: rtl/lrdf_front.sv
// ----------------------------------------------------------------------------
// lrdf_front: sample intake, hold logic and weighted vector accumulation
// Takes one ring sample per cycle while the queue has room, keeps the hold bits, the active count and
// the x/y sums, and pushes one frame record into the queue at the last index.
// ----------------------------------------------------------------------------
module lrdf_front #(
  parameter int NUM_SENSORS    = lrdf_pkg::NUM_SENSORS_DEF,
  parameter int COEF_FRAC_BITS = lrdf_pkg::COEF_FRAC_DEF,
  parameter int SUM_W          = COEF_FRAC_BITS + lrdf_pkg::WEIGHT_W + 1 + $clog2(NUM_SENSORS)
) (
  input  logic                           clk,
  input  logic                           rst,
  lrdf_sample_if.sink                    samples,
  input  logic                           cfg_we,
  input  logic [lrdf_pkg::SAMPLE_W-1:0]  cfg_wdata,
  input  lrdf_pkg::fifo_stat_t           stat,
  output logic                           push,
  output logic signed [SUM_W-1:0]        push_x,
  output logic signed [SUM_W-1:0]        push_y,
  output lrdf_pkg::frame_info_t          push_info
);
  import lrdf_pkg::*;

  localparam int HIDX_W = $clog2(NUM_SENSORS);
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + WEIGHT_W;

  logic [NUM_SENSORS-1:0]     held_active;
  logic [NUM_SENSORS-1:0]     held_next;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic signed [SUM_W-1:0]    sum_x_next;
  logic signed [SUM_W-1:0]    sum_y_next;
  logic signed [SUM_W-1:0]    base_x;
  logic signed [SUM_W-1:0]    base_y;
  logic [COUNT_W-1:0]         count_active;
  logic [COUNT_W-1:0]         count_base;
  logic [COUNT_W-1:0]         count_next;
  logic [SAMPLE_W-1:0]        side_threshold;
  logic [SAMPLE_W-1:0]        eff_sample;
  logic [HIDX_W-1:0]          hsel;
  logic                       fire;
  logic                       in_range;
  logic                       first;
  logic                       last;
  logic                       now_raw;
  logic                       held_hit;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [COEF_W-1:0]   coef_x;
  logic signed [COEF_W-1:0]   coef_y;
  logic signed [PROD_W-1:0]   prod_x;
  logic signed [PROD_W-1:0]   prod_y;

  // stall only when the queue has no room for a frame record
  assign samples.ready = !stat.full;
  assign fire          = samples.valid && samples.ready;

  always_comb begin
    in_range   = int'(samples.sensor_index) < NUM_SENSORS;
    first      = (samples.sensor_index == '0);
    last       = (int'(samples.sensor_index) == NUM_SENSORS - 1);
    hsel       = HIDX_W'(samples.sensor_index);
    now_raw    = samples.sensor_sample < samples.judge_level;
    held_hit   = !now_raw && held_active[hsel];
    eff_sample = held_hit ? SAMPLE_W'(HELD_VALUE) : samples.sensor_sample;
    weight     = $signed(WEIGHT_W'(WEIGHT_TOP) - {1'b0, eff_sample});
    coef_x     = COEF_W'(coef_of(samples.sensor_index, COEF_FRAC_BITS));
    coef_y     = COEF_W'(coef_of(samples.sensor_index + INDEX_W'(SIN_OFFSET),
                                 COEF_FRAC_BITS));
    prod_x     = coef_x * weight;
    prod_y     = coef_y * weight;
    base_x     = first ? '0 : sum_x;
    base_y     = first ? '0 : sum_y;
    sum_x_next = base_x + SUM_W'(prod_x);
    sum_y_next = base_y + SUM_W'(prod_y);
    count_base = first ? '0 : count_active;
    count_next = count_base
               + COUNT_W'(now_raw && (count_base != COUNT_W'(COUNT_MAX)));
    held_next       = held_active;
    held_next[hsel] = now_raw || held_hit;
    // no line this frame: drop every hold
    if (last && (count_next == '0)) begin
      held_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_active    <= '0;
      sum_x          <= '0;
      sum_y          <= '0;
      count_active   <= '0;
      side_threshold <= SAMPLE_W'(SIDE_RESET);
    end else begin
      if (cfg_we) begin
        side_threshold <= cfg_wdata;
      end
      if (fire && in_range) begin
        held_active <= held_next;
        if (last) begin
          sum_x        <= '0;
          sum_y        <= '0;
          count_active <= '0;
        end else begin
          sum_x        <= sum_x_next;
          sum_y        <= sum_y_next;
          count_active <= count_next;
        end
      end
    end
  end

  assign push                 = fire && in_range && last;
  assign push_x               = sum_x_next;
  assign push_y               = sum_y_next;
  assign push_info.count      = count_next;
  assign push_info.right_line = samples.right_sample > side_threshold;
  assign push_info.left_line  = samples.left_sample > side_threshold;
  assign push_info.back_line  = samples.back_sample > side_threshold;

endmodule

FILE: rtl/lrdf_fifo.sv
// ----------------------------------------------------------------------------
// lrdf_fifo: short frame record queue
// Register based first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module lrdf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrdf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rd_data,
  output lrdf_pkg::fifo_stat_t stat
);
  import lrdf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.full  = (fill == CNT_W'(DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/lrdf_back.sv
// ----------------------------------------------------------------------------
// lrdf_back: CORDIC angle engine and result register
// Pops a frame record, folds the vector into the first quadrant, runs one
// vectoring step per cycle and, once the result register is free, loads it on the last step.
// ----------------------------------------------------------------------------
module lrdf_back #(
  parameter int SUM_W = lrdf_pkg::COEF_FRAC_DEF + lrdf_pkg::WEIGHT_W + 1
                        + $clog2(lrdf_pkg::NUM_SENSORS_DEF)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [SUM_W-1:0] head_x,
  input  logic signed [SUM_W-1:0] head_y,
  input  lrdf_pkg::frame_info_t   head_info,
  input  lrdf_pkg::fifo_stat_t    stat,
  output logic                    pop,
  lrdf_result_if.source           results
);
  import lrdf_pkg::*;

  localparam int CW = SUM_W + PRESCALE + 2;
  localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [Z_W-1:0] Z_MAX    = Z_W'(FULL_TURN * DEG_ONE - 1);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_ITER = 2'b10
  } back_state_t;

  back_state_t          state;
  back_state_t          state_next;
  logic [STEP_W-1:0]    step;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;
  logic signed [Z_W-1:0] z;
  frame_info_t          cur_info;

  logic signed [CW-1:0]  hx;
  logic signed [CW-1:0]  hy;
  logic signed [CW-1:0]  lx;
  logic signed [CW-1:0]  ly;
  logic signed [Z_W-1:0] lz;
  logic signed [CW-1:0]  sx;
  logic signed [CW-1:0]  sy;
  logic signed [CW-1:0]  nx;
  logic signed [CW-1:0]  ny;
  logic signed [Z_W-1:0] nz;
  logic signed [Z_W-1:0] atan_z;
  logic signed [Z_W-1:0] zc;
  logic                  out_free;
  logic                  finish;
  logic                  advance;

  // quadrant fold of the queue head; axes land exactly on 0, 90, 180, 270
  always_comb begin
    hx = CW'(head_x);
    hy = CW'(head_y);
    if ((head_info.count == '0) || ((hx == '0) && (hy == '0))) begin
      lx = '0;
      ly = '0;
      lz = '0;
    end else if ((hy >= 0) && (hx > 0)) begin
      lx = hx;
      ly = hy;
      lz = '0;
    end else if ((hx <= 0) && (hy > 0)) begin
      lx = hy;
      ly = -hx;
      lz = Z_W'(QUARTER_Q16);
    end else if ((hy <= 0) && (hx < 0)) begin
      lx = -hx;
      ly = -hy;
      lz = Z_W'(2 * QUARTER_Q16);
    end else begin
      lx = -hy;
      ly = hx;
      lz = Z_W'(3 * QUARTER_Q16);
    end
    lx = lx <<< PRESCALE;
    ly = ly <<< PRESCALE;
  end

  // one vectoring step; y at zero stays put
  always_comb begin
    sx     = qx >>> step;
    sy     = qy >>> step;
    atan_z = Z_W'(ATAN_DEG_Q16[step]);
    if (qy == '0) begin
      nx = qx;
      ny = qy;
      nz = z;
    end else if (!qy[CW-1]) begin
      nx = qx + sy;
      ny = qy - sx;
      nz = z + atan_z;
    end else begin
      nx = qx - sy;
      ny = qy + sx;
      nz = z - atan_z;
    end
    if (nz < 0) begin
      zc = '0;
    end else if (nz > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = nz;
    end
  end

  assign out_free = !results.valid || results.ready;

  always_comb begin
    pop        = 1'b0;
    finish     = 1'b0;
    advance    = 1'b0;
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!stat.empty) begin
          pop        = 1'b1;
          state_next = B_ITER;
        end
      end
      B_ITER: begin
        if (step == LAST_STEP) begin
          if (out_free) begin
            finish = 1'b1;
            if (!stat.empty) begin
              pop = 1'b1;
            end else begin
              state_next = B_IDLE;
            end
          end
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      step          <= '0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        step <= '0;
      end else if (advance) begin
        step <= step + STEP_W'(1);
      end
      if (finish) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      qx       <= lx;
      qy       <= ly;
      z        <= lz;
      cur_info <= head_info;
    end else if (advance) begin
      qx <= nx;
      qy <= ny;
      z  <= nz;
    end
    if (finish) begin
      results.line_angle   <= ANGLE_W'(zc >>> DEG_SHIFT);
      results.line_seen    <= (cur_info.count != '0);
      results.active_count <= cur_info.count;
      results.right_line   <= cur_info.right_line;
      results.left_line    <= cur_info.left_line;
      results.back_line    <= cur_info.back_line;
    end
  end

endmodule

FILE: rtl/line_ring_direction_finder_unit.sv
// ----------------------------------------------------------------------------
// line_ring_direction_finder_unit: line direction from a ring of line sensors
// Usage: send the ring samples of one frame on 'samples', index 0 first and
// index NUM_SENSORS-1 last, one word per cycle; the side samples count only on
// the last word. Indexes at or above NUM_SENSORS are swallowed with no effect.
// Each frame yields one word on 'results': angle in degrees (0..359, truncated),
// line_seen, active_count and the three side-line flags.
// Throughput: one sample word per cycle while results are taken. The back part's
// CORDIC unit runs one vectoring step per cycle and keeps pace with the sample
// words of a frame; it works on frame n while frame n+1 streams in.
// Path: a frame record passes through the queue, is popped into the CORDIC
// registers and, after the last vectoring step, lands in the result register.
// Stall: a two-record queue sits between the front and back parts; if results
// is held off, the back part waits on its last step, the queue fills and then
// samples.ready drops at the next frame boundary, never inside a frame.
// Config: cfg_we/cfg_wdata write side_threshold (reset 500); write it only while
// the block is idle.
// Reset (rst, synchronous): clears holds, sums, count, queue and result valid.
// ----------------------------------------------------------------------------
module line_ring_direction_finder_unit #(
  parameter int NUM_SENSORS    = lrdf_pkg::NUM_SENSORS_DEF,
  parameter int COEF_FRAC_BITS = lrdf_pkg::COEF_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lrdf_sample_if.sink                   samples,
  lrdf_result_if.source                 results,
  input  logic                          cfg_we,
  input  logic [lrdf_pkg::SAMPLE_W-1:0] cfg_wdata
);
  import lrdf_pkg::*;

  // sum width covers NUM_SENSORS full-scale weights times a unit coefficient
  localparam int SUM_W  = COEF_FRAC_BITS + WEIGHT_W + 1 + $clog2(NUM_SENSORS);
  localparam int INFO_W = $bits(frame_info_t);
  localparam int REC_W  = 2 * SUM_W + INFO_W;

  logic                    push;
  logic                    pop;
  logic signed [SUM_W-1:0] push_x;
  logic signed [SUM_W-1:0] push_y;
  frame_info_t             push_info;
  logic [REC_W-1:0]        wr_rec;
  logic [REC_W-1:0]        rd_rec;
  logic signed [SUM_W-1:0] head_x;
  logic signed [SUM_W-1:0] head_y;
  frame_info_t             head_info;
  fifo_stat_t              stat;

  // front: classify samples, accumulate the frame vector
  lrdf_front #(
    .NUM_SENSORS   (NUM_SENSORS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .SUM_W         (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .stat     (stat),
    .push     (push),
    .push_x   (push_x),
    .push_y   (push_y),
    .push_info(push_info)
  );

  // pack the frame record for the queue
  assign wr_rec = {push_x, push_y, push_info};
  assign head_x    = rd_rec[REC_W-1 -: SUM_W];
  assign head_y    = rd_rec[INFO_W +: SUM_W];
  assign head_info = rd_rec[INFO_W-1:0];

  lrdf_fifo #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(wr_rec),
    .pop    (pop),
    .rd_data(rd_rec),
    .stat   (stat)
  );

  // back: angle by CORDIC, hold result until taken
  lrdf_back #(
    .SUM_W(SUM_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head_x   (head_x),
    .head_y   (head_y),
    .head_info(head_info),
    .stat     (stat),
    .pop      (pop),
    .results  (results)
  );

endmodule

FILE: rtl/lrdf_checker.sv
// ----------------------------------------------------------------------------
// lrdf_checker: port-level checks on the result channel
// Watches the result word over time and flags broken holds and bad fields.
// ----------------------------------------------------------------------------
module lrdf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [lrdf_pkg::ANGLE_W-1:0] line_angle,
  input logic                         line_seen,
  input logic [lrdf_pkg::COUNT_W-1:0] active_count,
  input logic                         right_line,
  input logic                         left_line,
  input logic                         back_line
);
  import lrdf_pkg::*;

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(line_angle) && $stable(line_seen)
      && $stable(active_count) && $stable(right_line) && $stable(left_line)
      && $stable(back_line))
    else $error("stalled result word changed");

  // angle stays inside a full turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (int'(line_angle) < FULL_TURN))
    else $error("line_angle out of range");

  // seen flag matches the count, and no line means angle zero
  a_seen_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (line_seen == (active_count != '0)) && (line_seen || (line_angle == '0)))
    else $error("line_seen inconsistent with active_count or line_angle");

endmodule

bind line_ring_direction_finder_unit lrdf_checker u_lrdf_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .line_angle  (results.line_angle),
  .line_seen   (results.line_seen),
  .active_count(results.active_count),
  .right_line  (results.right_line),
  .left_line   (results.left_line),
  .back_line   (results.back_line)
);

FILE: tb/lrdf_heading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrdf_heading_checker: result checker for the line ring direction finder
// Watches the sample, result and config ports and predicts each frame's
// heading word. Compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module lrdf_heading_checker (
  input  logic                          clk,
  input  logic                          rst,
  lrdf_sample_if                        samples,
  lrdf_result_if                        results,
  input  logic                          cfg_we,
  input  logic [lrdf_pkg::SAMPLE_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            open_count
);
  import lrdf_pkg::*;

  localparam int FULL_SCALE     = 1023;
  localparam int HOLD_LEVEL     = 10;
  localparam int SIDE_LEVEL_RST = 500;
  localparam int COUNT_CAP      = 31;
  localparam int LAST_INDEX     = NUM_SENSORS_DEF - 1;
  localparam int PRE_SHIFT      = 8;
  localparam int ROT_STEPS      = 16;
  localparam longint DEG_Q16    = 65536;
  localparam longint TURN_TOP   = 360 * DEG_Q16 - 1;

  // cos(k * 22.5 deg) in Q1.14
  localparam int COS_Q14 [16] = '{
    16384, 15137, 11585, 6270, 0, -6270, -11585, -15137,
    -16384, -15137, -11585, -6270, 0, 6270, 11585, 15137
  };

  // atan(2^-i) in degrees, Q16
  localparam longint ATAN_Q16 [ROT_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               seen;
    logic [COUNT_W-1:0] count;
    logic               right_on;
    logic               left_on;
    logic               back_on;
  } heading_word_t;

  heading_word_t        due_headings [$];
  logic [15:0]          held_mask;
  longint               acc_x;
  longint               acc_y;
  int                   lit_count;
  logic [SAMPLE_W-1:0]  side_level;
  int                   errs = 0;

  // Fold to the first quadrant by right angles, then vector with CORDIC.
  function automatic logic [ANGLE_W-1:0] cordic_heading(input longint x, input longint y);
    longint qx, qy, nx, ny, z, tot, base;
    if (x == 0 && y == 0) return '0;
    if (y >= 0 && x > 0) begin
      base = 0;   qx = x;  qy = y;
    end else if (x <= 0 && y > 0) begin
      base = 90;  qx = y;  qy = -x;
    end else if (y <= 0 && x < 0) begin
      base = 180; qx = -x; qy = -y;
    end else begin
      base = 270; qx = -y; qy = x;
    end
    z = 0;
    if (qy != 0) begin
      qx = qx <<< PRE_SHIFT;
      qy = qy <<< PRE_SHIFT;
      for (int i = 0; i < ROT_STEPS; i++) begin
        if (qy == 0) break;
        if (qy > 0) begin
          nx = qx + (qy >>> i);
          ny = qy - (qx >>> i);
          z  = z + ATAN_Q16[i];
        end else begin
          nx = qx - (qy >>> i);
          ny = qy + (qx >>> i);
          z  = z - ATAN_Q16[i];
        end
        qx = nx;
        qy = ny;
      end
    end
    tot = base * DEG_Q16 + z;
    if (tot < 0) tot = 0;
    if (tot > TURN_TOP) tot = TURN_TOP;
    return ANGLE_W'(tot / DEG_Q16);
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (errs < 40) begin
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    errs++;
  endtask

  task automatic fold_sample(input logic [SAMPLE_W-1:0] s_in, input logic [INDEX_W-1:0] k,
                             input logic [SAMPLE_W-1:0] judge,
                             input logic [SAMPLE_W-1:0] r_s, l_s, b_s);
    logic [SAMPLE_W-1:0] s;
    logic [INDEX_W-1:0]  ks;
    bit                  on;
    longint              w;
    heading_word_t       word;
    s  = s_in;
    ks = k + 4'd12;
    if (k == 0) begin
      acc_x = 0;
      acc_y = 0;
      lit_count = 0;
    end
    on = (s_in < judge);
    if (on && lit_count < COUNT_CAP) lit_count++;
    // a sensor that drops out after being active stays held until a frame with no active sensor
    if (!on && held_mask[k]) begin
      s  = SAMPLE_W'(HOLD_LEVEL);
      on = 1'b1;
    end
    w = longint'(FULL_SCALE) - longint'(s);
    acc_x += longint'(COS_Q14[k]) * w;
    acc_y += longint'(COS_Q14[ks]) * w;
    held_mask[k] = on;
    if (k == LAST_INDEX) begin
      if (lit_count == 0) begin
        held_mask  = '0;
        word.angle = '0;
        word.seen  = 1'b0;
      end else begin
        word.angle = cordic_heading(acc_x, acc_y);
        word.seen  = 1'b1;
      end
      word.count    = lit_count[COUNT_W-1:0];
      word.right_on = (r_s > side_level);
      word.left_on  = (l_s > side_level);
      word.back_on  = (b_s > side_level);
      due_headings.push_back(word);
      acc_x = 0;
      acc_y = 0;
      lit_count = 0;
    end
  endtask

  task automatic check_word();
    heading_word_t want;
    if (due_headings.size() == 0) begin
      report("result word with nothing due", results.line_angle, -1);
      return;
    end
    want = due_headings.pop_front();
    if (results.line_angle !== want.angle)
      report("line_angle", results.line_angle, want.angle);
    if (results.line_seen !== want.seen)
      report("line_seen", results.line_seen, want.seen);
    if (results.active_count !== want.count)
      report("active_count", results.active_count, want.count);
    if (results.right_line !== want.right_on)
      report("right_line", results.right_line, want.right_on);
    if (results.left_line !== want.left_on)
      report("left_line", results.left_line, want.left_on);
    if (results.back_line !== want.back_on)
      report("back_line", results.back_line, want.back_on);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_mask  = '0;
      acc_x      = 0;
      acc_y      = 0;
      lit_count  = 0;
      side_level = SAMPLE_W'(SIDE_LEVEL_RST);
      due_headings.delete();
    end else begin
      if (cfg_we) side_level = cfg_wdata;
      if (results.valid && results.ready) check_word();
      if (samples.valid && samples.ready) begin
        fold_sample(samples.sensor_sample, samples.sensor_index, samples.judge_level,
                    samples.right_sample, samples.left_sample, samples.back_sample);
      end
    end
    fail_count <= errs;
    open_count <= due_headings.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for line_ring_direction_finder_unit
// Drives sensor frames (directed corner frames, then random well-formed frames
// mixed with short, scrambled and overlong ones) across several side-threshold
// settings, paces the result side at random, and lets the checker judge.
// ----------------------------------------------------------------------------
module tb;
  import lrdf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  // Tail wait covers the result path plus one more frame of CORDIC work queued
  // ahead; leave margin.
  localparam int TAIL_CYCLES  = 60;
  localparam int LAST_INDEX   = NUM_SENSORS_DEF - 1;
  localparam int RING_SIZE    = NUM_SENSORS_DEF;
  localparam int TOP_SAMPLE   = 1023;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [SAMPLE_W-1:0] cfg_wdata;
  logic                take_ready = 1'b0;
  bit                  calm = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         cycle_count = 0;
  int                  fail_count;
  int                  open_count;

  // Stimulus bookkeeping and the drifting line arc used by random frames.
  int                  items_sent = 0;
  int                  frames_closed = 0;
  int                  arc_center = 0;
  int                  arc_width = 2;
  logic [SAMPLE_W-1:0] side_cfg = 10'd500;

  lrdf_sample_if smp ();
  lrdf_result_if res ();

  assign res.ready = take_ready;

  line_ring_direction_finder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp),
    .results   (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lrdf_heading_checker checker_u (
    .clk        (clk),
    .rst        (rst),
    .samples    (smp),
    .results    (res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("line_ring_direction_finder_unit test failed");
      $finish;
    end
  end

  // Result side pacing: after each word taken, draw a random hold-off and keep ready
  // low until it runs out; during calm stretches take every word at once.
  always @(posedge clk) begin : result_pace
    int unsigned n;
    if (rst) begin
      take_ready <= 1'b0;
      hold_left  <= 0;
    end else if (res.valid && take_ready) begin
      n = calm ? 0 : $urandom_range(0, 6);
      hold_left  <= n;
      take_ready <= (n == 0);
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      take_ready <= (hold_left == 1);
    end else begin
      take_ready <= 1'b1;
    end
  end

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic [INDEX_W-1:0] k,
                           input logic [SAMPLE_W-1:0] j,
                           input logic [SAMPLE_W-1:0] r, l, b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid         <= 1'b1;
    smp.sensor_sample <= s;
    smp.sensor_index  <= k;
    smp.judge_level   <= j;
    smp.right_sample  <= r;
    smp.left_sample   <= l;
    smp.back_sample   <= b;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    items_sent++;
    if (k == LAST_INDEX) frames_closed++;
  endtask

  // Side sample: often right at the threshold, to hit the strict compare.
  function automatic logic [SAMPLE_W-1:0] side_pick();
    int v;
    if ($urandom_range(0, 2) == 0) begin
      v = int'(side_cfg) + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > TOP_SAMPLE) v = TOP_SAMPLE;
    end else begin
      v = $urandom_range(0, TOP_SAMPLE);
    end
    return SAMPLE_W'(v);
  endfunction

  task automatic send_rand_word(input int s, input int k, input int j);
    send_word(SAMPLE_W'(s), INDEX_W'(k), SAMPLE_W'(j), side_pick(), side_pick(), side_pick());
  endtask

  // Well-formed frame: indexes 0..15 in order, a contiguous arc of sensors
  // below the judge level. The arc drifts between frames so holds kick in.
  task automatic ring_frame();
    logic [SAMPLE_W-1:0] j;
    logic [SAMPLE_W-1:0] s;
    int                  r;
    int                  d;
    bit                  lit;
    bit                  brink;
    r = $urandom_range(0, 9);
    j = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : SAMPLE_W'($urandom_range(1, TOP_SAMPLE));
    case ($urandom_range(0, 3))
      0: ;
      1: arc_center = (arc_center + 1) % RING_SIZE;
      2: arc_center = (arc_center + RING_SIZE - 1) % RING_SIZE;
      default: begin
        arc_center = $urandom_range(0, RING_SIZE - 1);
        arc_width  = $urandom_range(0, 5);
      end
    endcase
    for (int k = 0; k < RING_SIZE; k++) begin
      d = (k - arc_center + RING_SIZE) % RING_SIZE;
      if (d > RING_SIZE / 2) d = RING_SIZE - d;
      lit   = (d < arc_width);
      brink = ($urandom_range(0, 7) == 0);
      if (lit && j != 0) begin
        s = brink ? j - 10'd1 : SAMPLE_W'($urandom_range(0, j - 1));
      end else begin
        s = brink ? j : SAMPLE_W'($urandom_range(j, TOP_SAMPLE));
      end
      send_rand_word(s, k, j);
    end
  endtask

  // Short frame: start, a few scattered indexes, then the closing index.
  task automatic short_frame();
    send_rand_word($urandom_range(0, TOP_SAMPLE), 0, $urandom_range(0, TOP_SAMPLE));
    repeat ($urandom_range(0, 5)) begin
      send_rand_word($urandom_range(0, TOP_SAMPLE), $urandom_range(1, LAST_INDEX - 1),
                     $urandom_range(0, TOP_SAMPLE));
    end
    send_rand_word($urandom_range(0, TOP_SAMPLE), LAST_INDEX, $urandom_range(0, TOP_SAMPLE));
  endtask

  // Scrambled words: any index, any sample, any judge level.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      send_rand_word($urandom_range(0, TOP_SAMPLE), $urandom_range(0, LAST_INDEX),
                     $urandom_range(0, TOP_SAMPLE));
    end
  endtask

  // Overlong frame: more than 31 active words before the close, so the
  // active count saturates.
  task automatic long_frame();
    logic [SAMPLE_W-1:0] j;
    j = SAMPLE_W'($urandom_range(1, TOP_SAMPLE));
    send_rand_word($urandom_range(0, TOP_SAMPLE), 0, j);
    repeat ($urandom_range(32, 40)) begin
      send_rand_word($urandom_range(0, j - 1), $urandom_range(1, LAST_INDEX - 1), j);
    end
    send_rand_word($urandom_range(0, TOP_SAMPLE), LAST_INDEX, j);
  endtask

  // Drop valid, wait until every due word is back, then let the pipe drain.
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SAMPLE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    side_cfg   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int                  r;
    int                  mark_items;
    int                  mark_frames;
    logic [SAMPLE_W-1:0] thr;
    smp.valid         <= 1'b0;
    smp.sensor_sample <= '0;
    smp.sensor_index  <= '0;
    smp.judge_level   <= '0;
    smp.right_sample  <= '0;
    smp.left_sample   <= '0;
    smp.back_sample   <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst               <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners, at the reset threshold of 500.
    calm <= ($urandom_range(0, 1) == 0);
    // nothing active: no line; sides at full scale, zero and exactly 500
    send_word(10'd1023, 4'd15, 10'd0, 10'd1023, 10'd0, 10'd500);
    // one sensor on the left axis: exactly 90 degrees
    send_word(10'd0, 4'd4, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd1023, 10'd501, 10'd1023, 10'd0);
    // that sensor drops out: it is held but not counted, so no line and holds clear
    send_word(10'd1023, 4'd4, 10'd0, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd501, 10'd1023);
    // back axis: 180 degrees, then clear the hold with an empty frame
    send_word(10'd0, 4'd8, 10'd1, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd499, 10'd500, 10'd501);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd0, 10'd0);
    // right axis: 270 degrees, then clear
    send_word(10'd0, 4'd12, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd1023, 10'd1023, 10'd1023);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd0, 10'd0);
    // front and back cancel: zero vector with a line seen, then clear
    send_word(10'd0, 4'd0, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_word(10'd0, 4'd8, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd0, 10'd0);
    // last sensor alone: the highest ring angle, 337.5 degrees
    send_word(10'd0, 4'd15, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd0, 10'd0);
    // diagonal, between the axes
    send_word(10'd0, 4'd2, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_word(10'd1023, 4'd15, 10'd0, 10'd0, 10'd0, 10'd0);

    // Random phases, each at its own side threshold.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0:       thr = 10'd0;
        1:       thr = 10'd1023;
        2:       thr = SAMPLE_W'($urandom_range(1, TOP_SAMPLE - 1));
        default: thr = 10'd500;
      endcase
      write_threshold(thr);
      mark_items  = items_sent;
      mark_frames = frames_closed;
      if (phase == 1) long_frame();
      while (items_sent - mark_items < 90 || frames_closed - mark_frames < 5) begin
        calm <= ($urandom_range(0, 5) == 0);
        r = $urandom_range(0, 19);
        if (r < 14)      ring_frame();
        else if (r < 17) short_frame();
        else if (r < 19) noise_burst();
        else             long_frame();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("line_ring_direction_finder_unit test passed");
    end else begin
      $display("line_ring_direction_finder_unit test failed");
    end
    $finish;
  end

endmodule
